// ----- rtl/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg
// Types, character codes and digit helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned DigitW  = 7;

  // Character codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;

  // Radix values
  localparam logic [BaseW-1:0] BaseAuto  = 6'd0;
  localparam logic [BaseW-1:0] BaseMin   = 6'd2;
  localparam logic [BaseW-1:0] BaseOct   = 6'd8;
  localparam logic [BaseW-1:0] BaseDec   = 6'd10;
  localparam logic [BaseW-1:0] BaseHex   = 6'd16;
  localparam logic [BaseW-1:0] BaseMax   = 6'd36;
  localparam logic [BaseW-1:0] BaseReset = 6'd10;

  // Digit value of a non-digit character
  localparam logic [DigitW-1:0] DigitNone = 7'd99;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_X,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [ValueW-1:0]  parsed_value;
    logic [OffsetW-1:0] end_offset;
  } result_t;

  function automatic logic [DigitW-1:0] digit_of(input logic [7:0] c);
    logic [DigitW-1:0] d;
    d = DigitNone;
    if (c inside {[ChZero:ChNine]}) begin
      d = DigitW'(c - ChZero);
    end else if (c inside {[ChLowA:ChLowZ]}) begin
      d = DigitW'(c - ChLowA + 8'd10);
    end else if (c inside {[ChUpA:ChUpZ]}) begin
      d = DigitW'(c - ChUpA + 8'd10);
    end
    return d;
  endfunction

  function automatic logic digit_ok(input logic [DigitW-1:0] d,
                                    input logic [BaseW-1:0]  base);
    return (base >= BaseMin) && (base <= BaseMax) && (d < {1'b0, base});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {ChSpace, ChTab, ChLf, ChCr, ChVt, ChFf};
  endfunction

endpackage

// ----- rtl/aip_if.sv -----
// ----------------------------------------------------------------------------
// aip_if
// Valid/ready stream interfaces for parser bytes and parsed results.
// ----------------------------------------------------------------------------
interface aip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_start;

  modport source (output valid, output char_in, output string_start, input ready);
  modport sink   (input valid, input char_in, input string_start, output ready);
endinterface

interface aip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic [15:0] end_offset;

  modport source (output valid, output parsed_value, output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

// ----- rtl/aip_step.sv -----
// ----------------------------------------------------------------------------
// aip_step
// Parse state registers and the per-byte update: whitespace, sign, prefix and
// one multiply-add of the accumulator with the active radix.
// ----------------------------------------------------------------------------
module aip_step
  import aip_pkg::*;
#(
  parameter int unsigned OFFSET_LIMIT = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BaseW-1:0]    cfg_wdata_i,
  input  logic                fire_i,
  input  logic [7:0]          char_in_i,
  input  logic                string_start_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  localparam logic [OffsetW-1:0] CountMax =
      OffsetW'((OFFSET_LIMIT < 65535) ? OFFSET_LIMIT : 65535);

  logic [BaseW-1:0]   number_base_q;
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [BaseW-1:0]   base_q, base_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [OffsetW-1:0] cnt_q, cnt_d;

  phase_e             eff_phase;
  logic               eff_neg;
  logic [BaseW-1:0]   eff_base;
  logic [ValueW-1:0]  eff_acc;
  logic [OffsetW-1:0] eff_cnt;

  logic [DigitW-1:0]  digit;
  logic [ValueW-1:0]  acc_mac;
  logic [BaseW-1:0]   fc_base;
  logic               fc_zero;
  logic               do_first;

  function automatic logic [OffsetW-1:0] sat_add(input logic [OffsetW-1:0] cnt,
                                                 input logic [1:0]         n);
    logic [OffsetW:0] sum;
    sum = {1'b0, cnt} + (OffsetW+1)'(n);
    return (sum > {1'b0, CountMax}) ? CountMax : sum[OffsetW-1:0];
  endfunction

  // A new string clears the parse before its first byte is taken
  always_comb begin
    if (string_start_i) begin
      eff_phase = PH_WS;
      eff_neg   = 1'b0;
      eff_base  = '0;
      eff_acc   = '0;
      eff_cnt   = '0;
    end else begin
      eff_phase = phase_q;
      eff_neg   = neg_q;
      eff_base  = base_q;
      eff_acc   = acc_q;
      eff_cnt   = cnt_q;
    end
  end

  assign digit   = digit_of(char_in_i);
  assign acc_mac = eff_acc * ValueW'(eff_base) + ValueW'(digit);
  assign fc_zero = ((number_base_q == BaseAuto) || (number_base_q == BaseHex)) &&
                   (char_in_i == ChZero);
  assign fc_base = (number_base_q == BaseAuto) ? BaseDec : number_base_q;

  always_comb begin
    phase_d     = eff_phase;
    neg_d       = eff_neg;
    base_d      = eff_base;
    acc_d       = eff_acc;
    cnt_d       = eff_cnt;
    do_first    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (eff_phase)
      PH_WS: begin
        if (is_space(char_in_i)) begin
          cnt_d = sat_add(eff_cnt, 2'd1);
        end else if ((char_in_i == ChMinus) || (char_in_i == ChPlus)) begin
          neg_d   = (char_in_i == ChMinus);
          cnt_d   = sat_add(eff_cnt, 2'd1);
          phase_d = PH_SIGN;
        end else begin
          do_first = 1'b1;
        end
      end
      PH_SIGN: begin
        do_first = 1'b1;
      end
      PH_ZERO: begin
        if ((char_in_i == ChLowX) || (char_in_i == ChUpX)) begin
          base_d  = BaseHex;
          phase_d = PH_X;
        end else if (digit_ok(digit, eff_base)) begin
          acc_d   = ValueW'(digit);
          cnt_d   = sat_add(eff_cnt, 2'd1);
          phase_d = PH_DIGITS;
        end else begin
          res_valid_o = 1'b1;
          res_o       = '{parsed_value: '0, end_offset: eff_cnt};
          phase_d     = PH_DONE;
        end
      end
      PH_X: begin
        // The 'x' is counted only once a hex digit follows it
        if (digit_ok(digit, BaseHex)) begin
          acc_d   = ValueW'(digit);
          cnt_d   = sat_add(eff_cnt, 2'd2);
          phase_d = PH_DIGITS;
        end else begin
          res_valid_o = 1'b1;
          res_o       = '{parsed_value: '0, end_offset: eff_cnt};
          phase_d     = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit_ok(digit, eff_base)) begin
          acc_d = acc_mac;
          cnt_d = sat_add(eff_cnt, 2'd1);
        end else begin
          res_valid_o = 1'b1;
          res_o       = '{parsed_value: eff_neg ? (ValueW'(0) - eff_acc) : eff_acc,
                          end_offset: eff_cnt};
          phase_d     = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // First byte after whitespace and sign
    if (do_first) begin
      if (fc_zero) begin
        acc_d   = '0;
        base_d  = (number_base_q == BaseAuto) ? BaseOct : BaseHex;
        cnt_d   = sat_add(eff_cnt, 2'd1);
        phase_d = PH_ZERO;
      end else begin
        base_d = fc_base;
        if (digit_ok(digit, fc_base)) begin
          acc_d   = ValueW'(digit);
          cnt_d   = sat_add(eff_cnt, 2'd1);
          phase_d = PH_DIGITS;
        end else begin
          res_valid_o = 1'b1;
          res_o       = '{parsed_value: '0, end_offset: '0};
          phase_d     = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseReset;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      neg_q   <= 1'b0;
      base_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cnt_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountMax)
    else $error("consumed count above its limit");

  a_done_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !string_start_i && (phase_q == PH_DONE)) |-> !res_valid_o)
    else $error("result after the string already ended");

  a_res_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_valid_o) |=> (phase_q == PH_DONE))
    else $error("parse did not close after a result");

endmodule

// ----- rtl/aip_obuf.sv -----
// ----------------------------------------------------------------------------
// aip_obuf
// Two-entry result buffer: an output register backed by a skid register so
// the parser keeps taking bytes while a result waits.
// ----------------------------------------------------------------------------
module aip_obuf
  import aip_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  result_t           push_data_i,
  output logic              ready_o,
  aip_out_if.source         out_ch
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = main_valid_q && out_ch.ready;
  assign ready_o = !skid_valid_q;

  assign out_ch.valid        = main_valid_q;
  assign out_ch.parsed_value = main_q.parsed_value;
  assign out_ch.end_offset   = main_q.end_offset;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        // advance the skid entry; no push while it is full
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held with an empty output register");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !out_ch.ready) |=> (main_valid_q && $stable(main_q)))
    else $error("waiting result changed before it was taken");

endmodule

// ----- rtl/ascii_integer_parser_base.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser_base
// Streaming string-to-integer converter, one byte per handshake word.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the output buffer has room: the parse
// state and the 64-bit accumulator update in the same cycle the byte is
// accepted, with a single multiply-add of the accumulator by the 6-bit radix
// as the critical path. A result appears on the output in the cycle after its
// stopping byte is taken when no older result is still waiting in the buffer.
// Results go through a two-entry output buffer; the input stalls only when
// both entries hold results the consumer has not taken. number_base is
// sampled when the first byte after whitespace and sign arrives; the user
// must write it only while the parser is idle, which the block does not enforce.
module ascii_integer_parser_base
  import aip_pkg::*;
#(
  parameter int unsigned OFFSET_LIMIT = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BaseW-1:0] cfg_wdata_i,
  aip_in_if.sink           in_ch,
  aip_out_if.source        out_ch
);

  logic    fire;
  logic    buf_ready;
  logic    res_valid;
  result_t res;

  assign in_ch.ready = buf_ready;
  assign fire        = in_ch.valid && buf_ready;

  aip_step #(
    .OFFSET_LIMIT (OFFSET_LIMIT)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fire_i         (fire),
    .char_in_i      (in_ch.char_in),
    .string_start_i (in_ch.string_start),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  aip_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_ch      (out_ch)
  );

endmodule

// ----- bench/tb_ascii_integer_parser_base.sv -----
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser_base
// Self-checking bench for the streaming string-to-integer parser.
// ----------------------------------------------------------------------------
// Feeds strings one byte per word under random valid/ready gaps and checks
// each parsed value and end offset against a cycle-free model of the parse
// held in the bench. A short table of hand-checked strings comes first, then
// one long gap-free string that wraps the accumulator, then random strings
// under a range of radix settings.
module tb_ascii_integer_parser_base
  import aip_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OffsetCap  = 65535;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 45;
  localparam int unsigned LongDigits = 150;
  localparam int unsigned HoldCycles = 80;
  localparam logic [7:0]  ChNul      = 8'h00;

  typedef struct {
    logic [BaseW-1:0]   base;
    string              text;
    bit                 nul_end;
    bit                 known;
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] offset;
  } probe_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [BaseW-1:0] cfg_wdata_i;

  aip_in_if  in_ch ();
  aip_out_if out_ch ();

  ascii_integer_parser_base dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Hand-checked strings; the one row left unknown goes through the model.
  probe_row_t probe_rows [11] = '{
    '{BaseDec, " -12", 1'b1, 1'b1, -64'd12, 16'd4},
    '{BaseDec, "a", 1'b0, 1'b1, 64'd0, 16'd0},
    '{BaseDec, "7 9", 1'b0, 1'b1, 64'd7, 16'd1},
    '{BaseAuto, "0xF", 1'b1, 1'b1, 64'd15, 16'd3},
    '{BaseAuto, "0xg", 1'b0, 1'b1, 64'd0, 16'd1},
    '{BaseAuto, "07", 1'b1, 1'b1, 64'd7, 16'd2},
    '{BaseHex, "-0x7Fz", 1'b0, 1'b0, 64'd0, 16'd0},
    '{BaseMax, "z!", 1'b0, 1'b1, 64'd35, 16'd1},
    '{6'd1, "1", 1'b0, 1'b1, 64'd0, 16'd0},
    '{6'd63, "5", 1'b0, 1'b1, 64'd0, 16'd0},
    '{BaseMin, "\011\012\013\014\0151+", 1'b0, 1'b1, 64'd1, 16'd6}
  };

  logic [7:0] blank_set [6] = '{ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};
  logic [BaseW-1:0] phase_bases [10] = '{
    BaseAuto, BaseHex, BaseDec, BaseMin, BaseMax, BaseOct, 6'd1, 6'd63, BaseDec, BaseAuto
  };

  // Parse state mirrored by the bench
  logic [BaseW-1:0]   cfg_base;
  phase_e             pr_phase;
  bit                 pr_neg;
  logic [BaseW-1:0]   pr_radix;
  logic [ValueW-1:0]  pr_acc;
  logic [OffsetW-1:0] pr_count;

  result_t parsed_due [$];
  result_t due_r;
  int unsigned mismatches;
  int unsigned live_bytes;
  int unsigned cycle_count;
  bit idle_on;
  bit hold_req;
  int unsigned hold_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int char_digit(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c) - int'(ChZero);
    if (c >= ChLowA && c <= ChLowZ) return int'(c) - int'(ChLowA) + 10;
    if (c >= ChUpA && c <= ChUpZ) return int'(c) - int'(ChUpA) + 10;
    return 99;
  endfunction

  function automatic bit radix_ok(input int d, input logic [BaseW-1:0] radix);
    return radix >= BaseMin && radix <= BaseMax && d < int'(radix);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr || c == ChVt || c == ChFf;
  endfunction

  function automatic logic [OffsetW-1:0] sat_add(input logic [OffsetW-1:0] cnt, input int n);
    int unsigned sum;
    sum = int'(cnt) + n;
    return (sum > OffsetCap) ? OffsetW'(OffsetCap) : OffsetW'(sum);
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(1) ? ChLowA : ChUpA) + 8'(d - 10);
  endfunction

  task automatic clear_parse();
    pr_phase = PH_WS;
    pr_neg   = 1'b0;
    pr_radix = '0;
    pr_acc   = '0;
    pr_count = '0;
  endtask

  // First byte after whitespace and sign: pick the radix, take a digit or stop.
  task automatic lead_byte(input logic [7:0] c, input int d, output bit fired,
                           output result_t r);
    fired = 1'b0;
    r = '0;
    if ((cfg_base == BaseAuto || cfg_base == BaseHex) && c == ChZero) begin
      pr_acc   = '0;
      pr_radix = (cfg_base == BaseAuto) ? BaseOct : BaseHex;
      pr_count = sat_add(pr_count, 1);
      pr_phase = PH_ZERO;
    end else begin
      pr_radix = (cfg_base == BaseAuto) ? BaseDec : cfg_base;
      if (radix_ok(d, pr_radix)) begin
        pr_acc   = ValueW'(d);
        pr_count = sat_add(pr_count, 1);
        pr_phase = PH_DIGITS;
      end else begin
        fired    = 1'b1;
        pr_phase = PH_DONE;
      end
    end
  endtask

  task automatic strtol_step(input logic [7:0] c, input logic start, output bit fired,
                             output bit live, output result_t r);
    int d;
    d = char_digit(c);
    fired = 1'b0;
    r = '0;
    if (start) clear_parse();
    live = (pr_phase != PH_DONE);
    case (pr_phase)
      PH_WS: begin
        if (is_blank(c)) begin
          pr_count = sat_add(pr_count, 1);
        end else if (c == ChMinus || c == ChPlus) begin
          pr_neg   = (c == ChMinus);
          pr_count = sat_add(pr_count, 1);
          pr_phase = PH_SIGN;
        end else begin
          lead_byte(c, d, fired, r);
        end
      end
      PH_SIGN: lead_byte(c, d, fired, r);
      PH_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          pr_radix = BaseHex;
          pr_phase = PH_X;
        end else if (radix_ok(d, pr_radix)) begin
          pr_acc   = ValueW'(d);
          pr_count = sat_add(pr_count, 1);
          pr_phase = PH_DIGITS;
        end else begin
          fired = 1'b1;
          r.end_offset = pr_count;
          pr_phase = PH_DONE;
        end
      end
      PH_X: begin
        if (radix_ok(d, BaseHex)) begin
          pr_acc   = ValueW'(d);
          pr_count = sat_add(pr_count, 2);
          pr_phase = PH_DIGITS;
        end else begin
          fired = 1'b1;
          r.end_offset = pr_count;
          pr_phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (radix_ok(d, pr_radix)) begin
          pr_acc   = pr_acc * ValueW'(pr_radix) + ValueW'(d);
          pr_count = sat_add(pr_count, 1);
        end else begin
          fired = 1'b1;
          r.parsed_value = pr_neg ? -pr_acc : pr_acc;
          r.end_offset   = pr_count;
          pr_phase = PH_DONE;
        end
      end
      default: pr_phase = PH_DONE;
    endcase
  endtask

  // Offer one byte, hold it until taken, then log what it should produce.
  task automatic push_byte(input logic [7:0] c, input logic start, input bit use_typed,
                           input result_t typed);
    bit fired;
    bit live;
    result_t r;
    while (idle_on && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_in      <= c;
    in_ch.string_start <= start;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    strtol_step(c, start, fired, live, r);
    if (live) live_bytes++;
    if (fired) parsed_due.push_back(use_typed ? typed : r);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is out and the pipe is quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (parsed_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_base(input logic [BaseW-1:0] b);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    cfg_base = b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed numbers with random content, some noise and cut strings.
  task automatic random_string();
    logic [7:0] text_q [$];
    logic [BaseW-1:0] radix;
    int ndig;
    int pick;
    result_t none;
    none = '0;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(blank_set[$urandom_range(5)]);
      end
      pick = $urandom_range(99);
      if (pick < 30) text_q.push_back(ChMinus);
      else if (pick < 45) text_q.push_back(ChPlus);
      radix = (cfg_base >= BaseMin && cfg_base <= BaseMax) ? cfg_base : BaseDec;
      if (cfg_base == BaseAuto) begin
        pick = $urandom_range(2);
        radix = (pick == 0) ? BaseDec : (pick == 1) ? BaseOct : BaseHex;
        if (pick != 0) text_q.push_back(ChZero);
        if (pick == 2) text_q.push_back($urandom_range(1) ? ChLowX : ChUpX);
      end else if (cfg_base == BaseHex && $urandom_range(99) < 40) begin
        text_q.push_back(ChZero);
        text_q.push_back($urandom_range(1) ? ChLowX : ChUpX);
      end
      ndig = ($urandom_range(99) < 10) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (ndig) text_q.push_back(digit_char($urandom_range(int'(radix) - 1)));
      pick = $urandom_range(99);
      if (pick < 40) begin
        text_q.push_back(ChNul);
      end else if (pick < 75) begin
        text_q.push_back(8'($urandom_range(255)));
      end else if (pick >= 90) begin
        text_q.push_back(ChNul);
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      end
    end
    if (text_q.size() == 0) text_q.push_back(ChNul);
    foreach (text_q[k]) push_byte(text_q[k], k == 0, 1'b0, none);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (parsed_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value %h offset %0d", $time,
                 out_ch.parsed_value, out_ch.end_offset);
      end else begin
        due_r = parsed_due.pop_front();
        if (out_ch.parsed_value !== due_r.parsed_value) begin
          mismatches++;
          $display("%0t: parsed_value expected %h actual %h", $time,
                   due_r.parsed_value, out_ch.parsed_value);
        end
        if (out_ch.end_offset !== due_r.end_offset) begin
          mismatches++;
          $display("%0t: end_offset expected %0d actual %0d", $time,
                   due_r.end_offset, out_ch.end_offset);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL ascii_integer_parser_base");
      $finish;
    end
  end

  initial begin
    result_t row_exp;
    result_t none;
    none = '0;
    in_ch.valid        = 1'b0;
    in_ch.char_in      = '0;
    in_ch.string_start = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    rst_ni             = 1'b0;
    idle_on            = 1'b1;
    hold_req           = 1'b0;
    hold_left          = 0;
    mismatches         = 0;
    live_bytes         = 0;
    cycle_count        = 0;
    cfg_base           = BaseReset;
    clear_parse();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].base != cfg_base) set_base(probe_rows[i].base);
      row_exp = '{parsed_value: probe_rows[i].value, end_offset: probe_rows[i].offset};
      for (int k = 0; k < probe_rows[i].text.len(); k++) begin
        push_byte(probe_rows[i].text[k], k == 0, probe_rows[i].known, row_exp);
      end
      if (probe_rows[i].nul_end) push_byte(ChNul, 1'b0, probe_rows[i].known, row_exp);
    end

    // One long string that wraps the value, with no gaps on either side.
    set_base(BaseDec);
    idle_on = 1'b0;
    push_byte(ChNine, 1'b1, 1'b0, none);
    repeat (LongDigits) push_byte(digit_char($urandom_range(9)), 1'b0, 1'b0, none);
    push_byte(ChNul, 1'b0, 1'b0, none);
    idle_on = 1'b1;

    live_bytes = 0;
    foreach (phase_bases[p]) begin
      set_base((p == 8) ? BaseW'($urandom_range(63)) : phase_bases[p]);
      if (p == 3) hold_req = 1'b1;
      while (live_bytes < PhaseBytes * (p + 1)) begin
        random_string();
        if ($urandom_range(99) < 3) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS ascii_integer_parser_base");
    end else begin
      $display("FAIL ascii_integer_parser_base");
    end
    $finish;
  end

endmodule
